FILE: design/sqfa_pkg.sv
// sqfa_pkg: shared widths, status codes, register-file map and the fit microprogram
// used by sliding_quadratic_fit_apogee; depends on nothing
package sqfa_pkg;

   // field and datapath widths
   localparam int TW     = 12;   // sample time
   localparam int HW     = 20;   // altitude
   localparam int SW     = 3;    // status code
   localparam int BW     = 256;  // exact wide integer datapath
   localparam int LW     = 32;   // multiplier limb
   localparam int NLIMB  = BW / LW;
   localparam int RF_DEPTH = 32;
   localparam int RAW    = 5;
   localparam int UC_LEN = 103;
   localparam int PCW    = 7;
   localparam int MIN_FIT = 3;

   // result status codes
   localparam logic [SW-1:0] ST_OK       = 3'd0;
   localparam logic [SW-1:0] ST_FEW      = 3'd1;
   localparam logic [SW-1:0] ST_SINGULAR = 3'd2;
   localparam logic [SW-1:0] ST_NOTDOWN  = 3'd3;
   localparam logic [SW-1:0] ST_PASSED   = 3'd4;
   localparam logic [SW-1:0] ST_RANGE    = 3'd5;

   // request function codes
   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   // microinstruction opcodes
   typedef enum logic [3:0] {
      OP_LD, OP_MUL, OP_ADD, OP_SUB, OP_NEGIF, OP_DIV, OP_JMP, OP_JNF,
      OP_FEW, OP_BZ, OP_BDOWN, OP_BNEG, OP_BNN, OP_DONE
   } op_type;

   // register file map: running sums live in the first seven entries
   localparam logic [RAW-1:0] R_S1  = 5'd0;
   localparam logic [RAW-1:0] R_S2  = 5'd1;
   localparam logic [RAW-1:0] R_S3  = 5'd2;
   localparam logic [RAW-1:0] R_S4  = 5'd3;
   localparam logic [RAW-1:0] R_Y0  = 5'd4;
   localparam logic [RAW-1:0] R_Y1  = 5'd5;
   localparam logic [RAW-1:0] R_Y2  = 5'd6;
   localparam logic [RAW-1:0] R_S0  = 5'd7;
   localparam logic [RAW-1:0] R_T   = 5'd8;
   localparam logic [RAW-1:0] R_H   = 5'd9;
   localparam logic [RAW-1:0] R_T2  = 5'd10;
   localparam logic [RAW-1:0] R_T3  = 5'd11;
   localparam logic [RAW-1:0] R_T4  = 5'd12;
   localparam logic [RAW-1:0] R_TH  = 5'd13;
   localparam logic [RAW-1:0] R_T2H = 5'd14;
   localparam logic [RAW-1:0] R_MA  = 5'd15;
   localparam logic [RAW-1:0] R_MB  = 5'd16;
   localparam logic [RAW-1:0] R_MC  = 5'd17;
   localparam logic [RAW-1:0] R_MP  = 5'd18;
   localparam logic [RAW-1:0] R_MQ  = 5'd19;
   localparam logic [RAW-1:0] R_MR  = 5'd20;
   localparam logic [RAW-1:0] R_DD  = 5'd21;
   localparam logic [RAW-1:0] R_DA  = 5'd22;
   localparam logic [RAW-1:0] R_DB  = 5'd23;
   localparam logic [RAW-1:0] R_DC  = 5'd24;
   localparam logic [RAW-1:0] R_X   = 5'd25;
   localparam logic [RAW-1:0] R_Y   = 5'd26;
   localparam logic [RAW-1:0] R_NUM = 5'd27;
   localparam logic [RAW-1:0] R_DEN = 5'd28;
   localparam logic [RAW-1:0] R_TQ  = 5'd29;
   localparam logic [RAW-1:0] R_HQ  = 5'd30;
   localparam logic [RAW-1:0] R_Z   = 5'd31;

   // load sources, carried in the a field of a load
   localparam logic [RAW-1:0] SRC_ZERO  = 5'd0;
   localparam logic [RAW-1:0] SRC_NT    = 5'd1;
   localparam logic [RAW-1:0] SRC_NH    = 5'd2;
   localparam logic [RAW-1:0] SRC_OT    = 5'd3;
   localparam logic [RAW-1:0] SRC_OH    = 5'd4;
   localparam logic [RAW-1:0] SRC_CNT   = 5'd5;
   localparam logic [RAW-1:0] SRC_K4096 = 5'd6;

   localparam logic [PCW-1:0] PC_CLR  = 7'd0;
   localparam logic [PCW-1:0] PC_ADD  = 7'd8;
   localparam logic [PCW-1:0] PC_PRED = 7'd37;

   typedef struct packed {
      op_type           op;
      logic [RAW-1:0]   dst;
      logic [RAW-1:0]   a;
      logic [RAW-1:0]   b;
      logic [SW-1:0]    st;
   } uc_type;

   // microprogram: clear, add/remove sample, then the normal-equation solve
   localparam uc_type UCODE [UC_LEN] = '{
      // clear sums
      '{OP_LD,  R_S1, SRC_ZERO, R_S1, ST_OK},
      '{OP_LD,  R_S2, SRC_ZERO, R_S1, ST_OK},
      '{OP_LD,  R_S3, SRC_ZERO, R_S1, ST_OK},
      '{OP_LD,  R_S4, SRC_ZERO, R_S1, ST_OK},
      '{OP_LD,  R_Y0, SRC_ZERO, R_S1, ST_OK},
      '{OP_LD,  R_Y1, SRC_ZERO, R_S1, ST_OK},
      '{OP_LD,  R_Y2, SRC_ZERO, R_S1, ST_OK},
      '{OP_JMP, R_S1, R_S1, R_S1, ST_OK},
      // add the new sample
      '{OP_LD,  R_T,   SRC_NT, R_S1, ST_OK},
      '{OP_LD,  R_H,   SRC_NH, R_S1, ST_OK},
      '{OP_MUL, R_T2,  R_T,  R_T,  ST_OK},
      '{OP_MUL, R_T3,  R_T2, R_T,  ST_OK},
      '{OP_MUL, R_T4,  R_T2, R_T2, ST_OK},
      '{OP_MUL, R_TH,  R_T,  R_H,  ST_OK},
      '{OP_MUL, R_T2H, R_T2, R_H,  ST_OK},
      '{OP_ADD, R_S1,  R_S1, R_T,   ST_OK},
      '{OP_ADD, R_S2,  R_S2, R_T2,  ST_OK},
      '{OP_ADD, R_S3,  R_S3, R_T3,  ST_OK},
      '{OP_ADD, R_S4,  R_S4, R_T4,  ST_OK},
      '{OP_ADD, R_Y0,  R_Y0, R_H,   ST_OK},
      '{OP_ADD, R_Y1,  R_Y1, R_TH,  ST_OK},
      '{OP_ADD, R_Y2,  R_Y2, R_T2H, ST_OK},
      '{OP_JNF, R_S1,  R_S1, R_S1,  ST_OK},
      // remove the overwritten sample
      '{OP_LD,  R_T,   SRC_OT, R_S1, ST_OK},
      '{OP_LD,  R_H,   SRC_OH, R_S1, ST_OK},
      '{OP_MUL, R_T2,  R_T,  R_T,  ST_OK},
      '{OP_MUL, R_T3,  R_T2, R_T,  ST_OK},
      '{OP_MUL, R_T4,  R_T2, R_T2, ST_OK},
      '{OP_MUL, R_TH,  R_T,  R_H,  ST_OK},
      '{OP_MUL, R_T2H, R_T2, R_H,  ST_OK},
      '{OP_SUB, R_S1,  R_S1, R_T,   ST_OK},
      '{OP_SUB, R_S2,  R_S2, R_T2,  ST_OK},
      '{OP_SUB, R_S3,  R_S3, R_T3,  ST_OK},
      '{OP_SUB, R_S4,  R_S4, R_T4,  ST_OK},
      '{OP_SUB, R_Y0,  R_Y0, R_H,   ST_OK},
      '{OP_SUB, R_Y1,  R_Y1, R_TH,  ST_OK},
      '{OP_SUB, R_Y2,  R_Y2, R_T2H, ST_OK},
      // solve
      '{OP_FEW, R_S1, R_S1, R_S1, ST_FEW},
      '{OP_LD,  R_S0, SRC_CNT, R_S1, ST_OK},
      '{OP_MUL, R_X,  R_S2, R_S0, ST_OK},
      '{OP_MUL, R_Y,  R_S1, R_S1, ST_OK},
      '{OP_SUB, R_MA, R_X,  R_Y,  ST_OK},
      '{OP_MUL, R_X,  R_S3, R_S0, ST_OK},
      '{OP_MUL, R_Y,  R_S1, R_S2, ST_OK},
      '{OP_SUB, R_MB, R_X,  R_Y,  ST_OK},
      '{OP_MUL, R_X,  R_S3, R_S1, ST_OK},
      '{OP_MUL, R_Y,  R_S2, R_S2, ST_OK},
      '{OP_SUB, R_MC, R_X,  R_Y,  ST_OK},
      '{OP_MUL, R_X,  R_Y1, R_S0, ST_OK},
      '{OP_MUL, R_Y,  R_S1, R_Y0, ST_OK},
      '{OP_SUB, R_MP, R_X,  R_Y,  ST_OK},
      '{OP_MUL, R_X,  R_Y1, R_S1, ST_OK},
      '{OP_MUL, R_Y,  R_S2, R_Y0, ST_OK},
      '{OP_SUB, R_MQ, R_X,  R_Y,  ST_OK},
      '{OP_MUL, R_X,  R_S3, R_Y0, ST_OK},
      '{OP_MUL, R_Y,  R_Y1, R_S2, ST_OK},
      '{OP_SUB, R_MR, R_X,  R_Y,  ST_OK},
      // determinant of the system
      '{OP_MUL, R_X,  R_S4, R_MA, ST_OK},
      '{OP_MUL, R_Y,  R_S3, R_MB, ST_OK},
      '{OP_SUB, R_X,  R_X,  R_Y,  ST_OK},
      '{OP_MUL, R_Y,  R_S2, R_MC, ST_OK},
      '{OP_ADD, R_DD, R_X,  R_Y,  ST_OK},
      '{OP_BZ,  R_S1, R_DD, R_S1, ST_SINGULAR},
      // coefficient determinants
      '{OP_MUL, R_X,  R_Y2, R_MA, ST_OK},
      '{OP_MUL, R_Y,  R_S3, R_MP, ST_OK},
      '{OP_SUB, R_X,  R_X,  R_Y,  ST_OK},
      '{OP_MUL, R_Y,  R_S2, R_MQ, ST_OK},
      '{OP_ADD, R_DA, R_X,  R_Y,  ST_OK},
      '{OP_MUL, R_X,  R_S4, R_MP, ST_OK},
      '{OP_MUL, R_Y,  R_Y2, R_MB, ST_OK},
      '{OP_SUB, R_X,  R_X,  R_Y,  ST_OK},
      '{OP_MUL, R_Y,  R_S2, R_MR, ST_OK},
      '{OP_ADD, R_DB, R_X,  R_Y,  ST_OK},
      '{OP_MUL, R_X,  R_Y2, R_MC, ST_OK},
      '{OP_MUL, R_Y,  R_S4, R_MQ, ST_OK},
      '{OP_SUB, R_X,  R_X,  R_Y,  ST_OK},
      '{OP_MUL, R_Y,  R_S3, R_MR, ST_OK},
      '{OP_SUB, R_DC, R_X,  R_Y,  ST_OK},
      '{OP_BDOWN, R_S1, R_DA, R_DD, ST_NOTDOWN},
      // vertex time num/den with den positive
      '{OP_LD,    R_Z,   SRC_ZERO, R_S1, ST_OK},
      '{OP_SUB,   R_NUM, R_Z,   R_DB,  ST_OK},
      '{OP_ADD,   R_DEN, R_DA,  R_DA,  ST_OK},
      '{OP_NEGIF, R_NUM, R_NUM, R_DEN, ST_OK},
      '{OP_NEGIF, R_DEN, R_DEN, R_DEN, ST_OK},
      '{OP_LD,    R_X,   SRC_NT, R_S1, ST_OK},
      '{OP_MUL,   R_X,   R_X,   R_DEN, ST_OK},
      '{OP_SUB,   R_X,   R_NUM, R_X,   ST_OK},
      '{OP_BNEG,  R_S1,  R_X,   R_S1,  ST_PASSED},
      '{OP_LD,    R_X,   SRC_K4096, R_S1, ST_OK},
      '{OP_MUL,   R_X,   R_X,   R_DEN, ST_OK},
      '{OP_SUB,   R_X,   R_NUM, R_X,   ST_OK},
      '{OP_BNN,   R_S1,  R_X,   R_S1,  ST_RANGE},
      '{OP_DIV,   R_TQ,  R_NUM, R_DEN, ST_OK},
      // vertex altitude (4 Da Dc - Db^2) / (4 Da D)
      '{OP_MUL, R_X,   R_DA, R_DC, ST_OK},
      '{OP_ADD, R_X,   R_X,  R_X,  ST_OK},
      '{OP_ADD, R_X,   R_X,  R_X,  ST_OK},
      '{OP_MUL, R_Y,   R_DB, R_DB, ST_OK},
      '{OP_SUB, R_NUM, R_X,  R_Y,  ST_OK},
      '{OP_MUL, R_X,   R_DA, R_DD, ST_OK},
      '{OP_ADD, R_X,   R_X,  R_X,  ST_OK},
      '{OP_ADD, R_DEN, R_X,  R_X,  ST_OK},
      '{OP_DIV, R_HQ,  R_NUM, R_DEN, ST_OK},
      '{OP_DONE, R_S1, R_TQ, R_HQ, ST_OK}
   };

endpackage

FILE: design/sqfa_ram.sv
// sqfa_ram: generic single-write, single-read ram with registered read data
// no dependencies
module sqfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/sliding_quadratic_fit_apogee.sv
// sliding_quadratic_fit_apogee: sliding-window quadratic fit and apogee prediction
// depends on sqfa_pkg (types, microprogram) and sqfa_ram (sample store, register file)
//
//   channel | ports                                   | direction
//   req     | req_valid/ready, func, time, altitude   | in
//   rsp     | rsp_valid/ready, status, time, alt, cnt | out
//
// one item at a time; a shared 32x32 multiplier, a 256-bit adder and a one-bit-per-cycle
// divider run under a microprogram sequencer; an add that fits is dominated by its two
// divisions and the limb-serial multiplies (one partial product per cycle)
// after reset a clearing pass zeroes the sums; req_ready stays low
// a finished beat waits in the rsp register; the next req beat is taken meanwhile
module sliding_quadratic_fit_apogee #(
   parameter int WINDOW = 64,
   localparam int CW = $clog2(WINDOW + 1),
   localparam int AW = $clog2(WINDOW)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [11:0]          req_sample_time,
   input  logic signed [19:0]   req_sample_altitude,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [11:0]          rsp_apogee_time,
   output logic signed [19:0]   rsp_apogee_altitude,
   output logic [CW-1:0]        rsp_sample_count
);

   typedef enum logic [3:0] {
      S_IDLE, S_OLD, S_FETCH, S_EXEC, S_MCNT, S_MRUN, S_MDRAIN, S_DRUN, S_WB, S_RESP
   } state_type;

   localparam int BW = sqfa_pkg::BW;
   localparam int LW = sqfa_pkg::LW;
   localparam int TW = sqfa_pkg::TW;
   localparam int HW = sqfa_pkg::HW;

   state_type                     state_ff;
   logic [sqfa_pkg::PCW-1:0]      pc_ff;
   logic                          init_ff;
   logic [CW-1:0]                 fill_ff;
   logic [AW-1:0]                 wp_ff;
   logic                          full_ff;
   logic [TW-1:0]                 nt_ff;
   logic [HW-1:0]                 nh_ff;
   logic [TW-1:0]                 ot_ff;
   logic [HW-1:0]                 oh_ff;
   logic [BW-1:0]                 ma_ff;
   logic [BW-1:0]                 mb_ff;
   logic                          neg_ff;
   logic [3:0]                    na_ff;
   logic [3:0]                    nb_ff;
   logic [2:0]                    i_ff;
   logic [2:0]                    j_ff;
   logic [2*LW-1:0]               prod_ff;
   logic [2:0]                    pos_ff;
   logic                          pv_ff;
   logic [BW-1:0]                 acc_ff;
   logic [BW-1:0]                 rem_ff;
   logic [7:0]                    cnt_ff;
   logic [2:0]                    pst_ff;
   logic [TW-1:0]                 ptime_ff;
   logic [HW-1:0]                 palt_ff;
   logic [CW-1:0]                 pcnt_ff;
   logic                          rsp_valid_ff;
   logic [2:0]                    rsp_status_ff;
   logic [TW-1:0]                 rsp_time_ff;
   logic [HW-1:0]                 rsp_alt_ff;
   logic [CW-1:0]                 rsp_cnt_ff;

   sqfa_pkg::uc_type              ins;
   logic [BW-1:0]                 rf_a;
   logic [BW-1:0]                 rf_b;
   logic                          rf_we;
   logic [BW-1:0]                 rf_wd;
   logic [BW-1:0]                 alu;
   logic [TW+HW-1:0]              st_rd;
   logic                          st_we;
   logic [BW-1:0]                 acc_in;
   logic [BW-1:0]                 rem_in;
   logic [BW:0]                   div_diff;
   logic [BW-1:0]                 div_shift;
   logic [AW-1:0]                 wp_in;

   // magnitude of a two's complement wide value
   function automatic logic [BW-1:0] mag(input logic [BW-1:0] x);
      return x[BW-1] ? (~x + BW'(1)) : x;
   endfunction

   // number of significant limbs, at least one
   function automatic logic [3:0] limbs(input logic [BW-1:0] x);
      logic [3:0] n;
      n = 4'd1;
      for (int k = 0; k < sqfa_pkg::NLIMB; k++) begin
         if (x[k*LW +: LW] != '0) begin
            n = 4'(k + 1);
         end
      end
      return n;
   endfunction

   // clamp a wide signed quotient to the altitude range
   function automatic logic [HW-1:0] sat_alt(input logic [BW-1:0] x);
      logic [HW-1:0] r;
      if (!x[BW-1] && (|x[BW-2:HW-1])) begin
         r = {1'b0, {(HW-1){1'b1}}};
      end else if (x[BW-1] && !(&x[BW-2:HW-1])) begin
         r = {1'b1, {(HW-1){1'b0}}};
      end else begin
         r = x[HW-1:0];
      end
      return r;
   endfunction

   assign ins = sqfa_pkg::UCODE[pc_ff];

   // sample store: time and altitude side by side
   sqfa_ram #(.WIDTH(TW + HW), .DEPTH(WINDOW)) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (wp_ff),
      .wr_data ({nt_ff, nh_ff}),
      .rd_addr (wp_ff),
      .rd_data (st_rd)
   );

   // register file, two copies for two read ports
   sqfa_ram #(.WIDTH(BW), .DEPTH(sqfa_pkg::RF_DEPTH)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (ins.dst),
      .wr_data (rf_wd),
      .rd_addr (ins.a),
      .rd_data (rf_a)
   );

   sqfa_ram #(.WIDTH(BW), .DEPTH(sqfa_pkg::RF_DEPTH)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (ins.dst),
      .wr_data (rf_wd),
      .rd_addr (ins.b),
      .rd_data (rf_b)
   );

   assign st_we = (state_ff == S_OLD);
   assign wp_in = (wp_ff == AW'(WINDOW - 1)) ? '0 : wp_ff + AW'(1);

   // combinational alu and load sources
   always_comb begin
      alu = '0;
      case (ins.op)
         sqfa_pkg::OP_ADD:   alu = rf_a + rf_b;
         sqfa_pkg::OP_SUB:   alu = rf_a - rf_b;
         sqfa_pkg::OP_NEGIF: alu = rf_b[BW-1] ? (~rf_a + BW'(1)) : rf_a;
         sqfa_pkg::OP_LD: begin
            case (ins.a)
               sqfa_pkg::SRC_NT:    alu = BW'(nt_ff);
               sqfa_pkg::SRC_NH:    alu = {{(BW-HW){nh_ff[HW-1]}}, nh_ff};
               sqfa_pkg::SRC_OT:    alu = BW'(ot_ff);
               sqfa_pkg::SRC_OH:    alu = {{(BW-HW){oh_ff[HW-1]}}, oh_ff};
               sqfa_pkg::SRC_CNT:   alu = BW'(fill_ff);
               sqfa_pkg::SRC_K4096: alu = BW'(1) << TW;
               default:             alu = '0;
            endcase
         end
         default: alu = '0;
      endcase
   end

   // register file write: alu ops in exec, mul/div results in writeback
   always_comb begin
      rf_we = 1'b0;
      rf_wd = alu;
      if (state_ff == S_EXEC && (ins.op inside {sqfa_pkg::OP_LD, sqfa_pkg::OP_ADD,
                                                sqfa_pkg::OP_SUB, sqfa_pkg::OP_NEGIF})) begin
         rf_we = 1'b1;
      end else if (state_ff == S_WB) begin
         rf_we = 1'b1;
         rf_wd = neg_ff ? (~acc_ff + BW'(1)) : acc_ff;
      end
   end

   // divider step and multiplier accumulate
   always_comb begin
      div_shift = {rem_ff[BW-2:0], ma_ff[BW-1]};
      div_diff  = {1'b0, div_shift} - {1'b0, mb_ff};
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      if (state_ff == S_DRUN) begin
         if (!div_diff[BW]) begin
            rem_in = div_diff[BW-1:0];
            acc_in = {acc_ff[BW-2:0], 1'b1};
         end else begin
            rem_in = div_shift;
            acc_in = {acc_ff[BW-2:0], 1'b0};
         end
      end else if (pv_ff) begin
         acc_in = acc_ff + (BW'(prod_ff) << (32'(pos_ff) * LW));
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FETCH;
         pc_ff        <= sqfa_pkg::PC_CLR;
         init_ff      <= 1'b1;
         fill_ff      <= '0;
         wp_ff        <= '0;
         full_ff      <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pv_ff  <= (state_ff == S_MRUN);
         acc_ff <= acc_in;
         rem_ff <= rem_in;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  nt_ff <= req_sample_time;
                  nh_ff <= req_sample_altitude;
                  if (req_func == sqfa_pkg::FUNC_CLEAR) begin
                     fill_ff  <= '0;
                     wp_ff    <= '0;
                     pc_ff    <= sqfa_pkg::PC_CLR;
                     state_ff <= S_FETCH;
                  end else begin
                     state_ff <= S_OLD;
                  end
               end
            end
            // old entry at the write pointer is on the read port; new beat is written
            S_OLD: begin
               ot_ff    <= st_rd[TW+HW-1:HW];
               oh_ff    <= st_rd[HW-1:0];
               full_ff  <= (fill_ff == CW'(WINDOW));
               wp_ff    <= wp_in;
               if (fill_ff != CW'(WINDOW)) begin
                  fill_ff <= fill_ff + CW'(1);
               end
               pc_ff    <= sqfa_pkg::PC_ADD;
               state_ff <= S_FETCH;
            end
            S_FETCH: state_ff <= S_EXEC;
            S_EXEC: begin
               pc_ff    <= pc_ff + 1'b1;
               state_ff <= S_FETCH;
               case (ins.op)
                  sqfa_pkg::OP_MUL: begin
                     pc_ff    <= pc_ff;
                     ma_ff    <= mag(rf_a);
                     mb_ff    <= mag(rf_b);
                     neg_ff   <= rf_a[BW-1] ^ rf_b[BW-1];
                     acc_ff   <= '0;
                     state_ff <= S_MCNT;
                  end
                  sqfa_pkg::OP_DIV: begin
                     pc_ff    <= pc_ff;
                     ma_ff    <= mag(rf_a);
                     mb_ff    <= mag(rf_b);
                     neg_ff   <= rf_a[BW-1] ^ rf_b[BW-1];
                     acc_ff   <= '0;
                     rem_ff   <= '0;
                     cnt_ff   <= 8'(BW - 1);
                     state_ff <= S_DRUN;
                  end
                  sqfa_pkg::OP_JMP: pc_ff <= sqfa_pkg::PC_PRED;
                  sqfa_pkg::OP_JNF: begin
                     if (!full_ff) begin
                        pc_ff <= sqfa_pkg::PC_PRED;
                     end
                  end
                  sqfa_pkg::OP_FEW: begin
                     if (fill_ff < CW'(sqfa_pkg::MIN_FIT)) begin
                        pst_ff   <= ins.st;
                        state_ff <= S_RESP;
                     end
                  end
                  sqfa_pkg::OP_BZ: begin
                     if (rf_a == '0) begin
                        pst_ff   <= ins.st;
                        state_ff <= S_RESP;
                     end
                  end
                  sqfa_pkg::OP_BDOWN: begin
                     if (rf_a == '0 || rf_a[BW-1] == rf_b[BW-1]) begin
                        pst_ff   <= ins.st;
                        state_ff <= S_RESP;
                     end
                  end
                  sqfa_pkg::OP_BNEG: begin
                     if (rf_a[BW-1]) begin
                        pst_ff   <= ins.st;
                        state_ff <= S_RESP;
                     end
                  end
                  sqfa_pkg::OP_BNN: begin
                     if (!rf_a[BW-1]) begin
                        pst_ff   <= ins.st;
                        state_ff <= S_RESP;
                     end
                  end
                  sqfa_pkg::OP_DONE: begin
                     pst_ff   <= sqfa_pkg::ST_OK;
                     ptime_ff <= rf_a[TW-1:0];
                     palt_ff  <= sat_alt(rf_b);
                     state_ff <= S_RESP;
                  end
                  default: ;
               endcase
               pcnt_ff <= fill_ff;
            end
            // limb counts bound the partial-product sweep
            S_MCNT: begin
               na_ff    <= limbs(ma_ff);
               nb_ff    <= limbs(mb_ff);
               i_ff     <= '0;
               j_ff     <= '0;
               state_ff <= S_MRUN;
            end
            // one 32x32 partial product per cycle, truncated to the datapath width
            S_MRUN: begin
               prod_ff <= ma_ff[i_ff*LW +: LW] * mb_ff[j_ff*LW +: LW];
               pos_ff  <= i_ff + j_ff;
               if (({1'b0, j_ff} == nb_ff - 4'd1) ||
                   ((4'(i_ff) + 4'(j_ff)) == 4'(sqfa_pkg::NLIMB - 1))) begin
                  j_ff <= '0;
                  i_ff <= i_ff + 3'd1;
                  if ({1'b0, i_ff} == na_ff - 4'd1) begin
                     state_ff <= S_MDRAIN;
                  end
               end else begin
                  j_ff <= j_ff + 3'd1;
               end
            end
            S_MDRAIN: state_ff <= S_WB;
            // restoring division, one quotient bit per cycle
            S_DRUN: begin
               ma_ff <= {ma_ff[BW-2:0], 1'b0};
               if (cnt_ff == '0) begin
                  state_ff <= S_WB;
               end else begin
                  cnt_ff <= cnt_ff - 8'd1;
               end
            end
            S_WB: begin
               pc_ff    <= pc_ff + 1'b1;
               state_ff <= S_FETCH;
            end
            // hand the result to the output register once it is free; the pass after reset gives none
            S_RESP: begin
               if (init_ff) begin
                  init_ff  <= 1'b0;
                  state_ff <= S_IDLE;
               end else if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= pst_ff;
                  rsp_time_ff   <= (pst_ff == sqfa_pkg::ST_OK) ? ptime_ff : '0;
                  rsp_alt_ff    <= (pst_ff == sqfa_pkg::ST_OK) ? palt_ff : '0;
                  rsp_cnt_ff    <= pcnt_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_apogee_time     = rsp_time_ff;
   assign rsp_apogee_altitude = rsp_alt_ff;
   assign rsp_sample_count    = rsp_cnt_ff;

endmodule
